[src/hcbd_pkg.sv]
// Shared types and constants for the HTTP chunked body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS       = 64;
    localparam int MAX_SIZE_DIGITS = 16;
    localparam int DIGIT_CNT_BITS  = $clog2(MAX_SIZE_DIGITS + 1);

    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic       sink_refuse;
        logic       buffer_last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
    } t_item;

    typedef struct packed {
        logic [7:0]           payload_byte;
        logic                 payload_valid;
        logic [1:0]           status;
        logic                 status_report;
        logic [SIZE_BITS-1:0] body_total;
    } t_result;

endpackage

`default_nettype wire

[src/hcbd_front.sv]
// Front end that classifies each incoming byte of the chunked stream.
`default_nettype none

module hcbd_front
    import hcbd_pkg::*;
(
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_restart,
    input  wire logic       i_sink_refuse,
    input  wire logic       i_buffer_last,
    output t_item           o_item
);

    always_comb begin
        o_item.in_byte     = i_in_byte;
        o_item.restart     = i_restart;
        o_item.sink_refuse = i_sink_refuse;
        o_item.buffer_last = i_buffer_last;
        o_item.is_cr       = (i_in_byte == CHAR_CR);
        o_item.is_lf       = (i_in_byte == CHAR_LF);
        o_item.is_semi     = (i_in_byte == CHAR_SEMI);
        o_item.is_hex      = 1'b1;
        o_item.hex_val     = 4'd0;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            o_item.hex_val = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte inside {[8'h61:8'h66]}) begin
            o_item.hex_val = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte inside {[8'h41:8'h46]}) begin
            o_item.hex_val = 4'(i_in_byte - 8'h37);
        end else begin
            o_item.is_hex = 1'b0;
        end
    end

endmodule

`default_nettype wire

[src/hcbd_queue.sv]
// Short queue of classified bytes between the front end and the decoder core.
`default_nettype none

module hcbd_queue
    import hcbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_item     i_wr_item,
    output logic      o_full,
    input  wire logic i_rd,
    output t_item     o_rd_item,
    output logic      o_valid
);

    t_item                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wp;
    logic [QUEUE_PTR_BITS-1:0] r_rp;
    logic [QUEUE_CNT_BITS-1:0] r_cnt;
    logic                      w_wr;
    logic                      w_rd;

    assign o_full    = (r_cnt == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rd_item = r_mem[r_rp];
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

endmodule

`default_nettype wire

[src/hcbd_back.sv]
// Decoder core: chunk framing state machine and result queue.
`default_nettype none

module hcbd_back
    import hcbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_item     i_item,
    input  wire logic i_item_valid,
    output logic      o_take,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_result
);

    typedef enum logic [3:0] {
        PH_SIZE       = 4'd0,
        PH_EXT        = 4'd1,
        PH_SIZE_LF    = 4'd2,
        PH_DATA       = 4'd3,
        PH_DATA_END   = 4'd4,
        PH_TRAILER    = 4'd5,
        PH_TRAILER_LF = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [SIZE_BITS-1:0]      r_size_acc, n_size_acc;
    logic [DIGIT_CNT_BITS-1:0] r_digit_cnt, n_digit_cnt;
    logic [SIZE_BITS-1:0]      r_left, n_left;
    logic                      r_line_flag, n_line_flag;
    logic [SIZE_BITS-1:0]      r_payload_cnt, n_payload_cnt;

    t_result                   r_out [2];
    logic                      r_out_wp;
    logic                      r_out_rp;
    logic [1:0]                r_out_cnt;
    t_result                   w_res;
    logic                      w_pop;

    assign w_pop    = i_pop && (r_out_cnt != 2'd0);
    assign o_take   = i_item_valid && ((r_out_cnt != 2'd2) || w_pop);
    assign o_empty  = (r_out_cnt == 2'd0);
    assign o_result = r_out[r_out_rp];

    always_comb begin
        n_phase       = r_phase;
        n_size_acc    = r_size_acc;
        n_digit_cnt   = r_digit_cnt;
        n_left        = r_left;
        n_line_flag   = r_line_flag;
        n_payload_cnt = r_payload_cnt;
        w_res.payload_byte  = 8'd0;
        w_res.payload_valid = 1'b0;
        if (i_item.restart) begin
            n_phase       = PH_SIZE;
            n_size_acc    = '0;
            n_digit_cnt   = '0;
            n_left        = '0;
            n_line_flag   = 1'b0;
            n_payload_cnt = '0;
        end else begin
            case (r_phase)
                PH_SIZE: begin
                    if (i_item.is_hex) begin
                        if ((r_digit_cnt >= DIGIT_CNT_BITS'(MAX_SIZE_DIGITS))
                            || (r_size_acc[SIZE_BITS-1 -: 4] != 4'd0)) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_size_acc  = {r_size_acc[SIZE_BITS-5:0], i_item.hex_val};
                            n_digit_cnt = r_digit_cnt + 1'b1;
                        end
                    end else if (i_item.is_semi || i_item.is_cr) begin
                        if (r_digit_cnt == '0) begin
                            n_phase = PH_ERROR;
                        end else if (i_item.is_semi) begin
                            n_phase = PH_EXT;
                        end else begin
                            n_phase = PH_SIZE_LF;
                        end
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_EXT: begin
                    if (i_item.is_cr) begin
                        n_phase = PH_SIZE_LF;
                    end
                end
                PH_SIZE_LF: begin
                    if (!i_item.is_lf) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_left      = r_size_acc;
                        n_size_acc  = '0;
                        n_digit_cnt = '0;
                        if (r_size_acc == '0) begin
                            n_phase     = PH_TRAILER;
                            n_line_flag = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (i_item.sink_refuse) begin
                        n_phase = PH_ERROR;
                    end else begin
                        w_res.payload_byte  = i_item.in_byte;
                        w_res.payload_valid = 1'b1;
                        n_payload_cnt       = r_payload_cnt + 1'b1;
                        n_left              = r_left - 1'b1;
                        if (r_left == SIZE_BITS'(1)) begin
                            n_phase     = PH_DATA_END;
                            n_line_flag = 1'b0;
                        end
                    end
                end
                PH_DATA_END: begin
                    if (r_line_flag) begin
                        if (!i_item.is_lf) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_line_flag = 1'b0;
                            n_phase     = PH_SIZE;
                        end
                    end else if (i_item.is_cr) begin
                        n_line_flag = 1'b1;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAILER: begin
                    if (i_item.is_cr) begin
                        n_phase = PH_TRAILER_LF;
                    end else begin
                        n_line_flag = 1'b0;
                    end
                end
                PH_TRAILER_LF: begin
                    if (!i_item.is_lf) begin
                        n_phase = PH_ERROR;
                    end else if (r_line_flag) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_line_flag = 1'b1;
                        n_phase     = PH_TRAILER;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
        case (n_phase)
            PH_DONE:  w_res.status = ST_DONE;
            PH_ERROR: w_res.status = ST_ERROR;
            default:  w_res.status = ST_MORE;
        endcase
        w_res.status_report = i_item.buffer_last;
        w_res.body_total    = n_payload_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SIZE;
            r_size_acc    <= '0;
            r_digit_cnt   <= '0;
            r_left        <= '0;
            r_line_flag   <= 1'b0;
            r_payload_cnt <= '0;
            r_out_wp      <= 1'b0;
            r_out_rp      <= 1'b0;
            r_out_cnt     <= 2'd0;
        end else begin
            if (o_take) begin
                r_phase       <= n_phase;
                r_size_acc    <= n_size_acc;
                r_digit_cnt   <= n_digit_cnt;
                r_left        <= n_left;
                r_line_flag   <= n_line_flag;
                r_payload_cnt <= n_payload_cnt;
                r_out_wp      <= !r_out_wp;
            end
            if (w_pop) begin
                r_out_rp <= !r_out_rp;
            end
            if (o_take && !w_pop) begin
                r_out_cnt <= r_out_cnt + 2'd1;
            end else if (w_pop && !o_take) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
        end
        if (o_take) begin
            r_out[r_out_wp] <= w_res;
        end
    end

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("Result queue count out of range.");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_cnt <= DIGIT_CNT_BITS'(MAX_SIZE_DIGITS))
        else $error("Size digit count exceeds the limit.");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("Data phase with no bytes left in the chunk.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !i_item.restart && r_phase == PH_DATA && !i_item.sink_refuse
        |=> r_payload_cnt == $past(r_payload_cnt) + SIZE_BITS'(1))
        else $error("Payload count did not advance on a data byte.");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !i_item.restart && r_phase == PH_DONE |=> r_phase == PH_DONE)
        else $error("Decoder left the done state without a restart.");

endmodule

`default_nettype wire

[src/http_chunked_body_decoder.sv]
// Top level of the HTTP/1.1 chunked transfer body decoder.
// A byte is registered in the intake queue; the core decodes it and registers its result
// in the result queue that drives the outputs; a full, unpopped result queue stalls the core.
// Throughput: one byte per cycle unless stalled, set by the framing state machine in the core.
// A four-entry queue decouples intake from the core; a two-entry queue holds results.
// Reset is synchronous and active low; it empties both queues and returns the decoder
// to the size-line state with all counters cleared.
`default_nettype none

module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_restart,
    input  wire logic                 i_sink_refuse,
    input  wire logic                 i_buffer_last,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_payload_byte,
    output logic                      o_payload_valid,
    output logic [1:0]                o_status,
    output logic                      o_status_report,
    output logic [SIZE_BITS-1:0]      o_body_total
);

    t_item   w_front_item;
    t_item   w_core_item;
    logic    w_core_valid;
    logic    w_core_take;
    t_result w_result;

    hcbd_front u_front (
        .i_in_byte     (i_in_byte),
        .i_restart     (i_restart),
        .i_sink_refuse (i_sink_refuse),
        .i_buffer_last (i_buffer_last),
        .o_item        (w_front_item)
    );

    hcbd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (w_front_item),
        .o_full    (full),
        .i_rd      (w_core_take),
        .o_rd_item (w_core_item),
        .o_valid   (w_core_valid)
    );

    hcbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_core_item),
        .i_item_valid (w_core_valid),
        .o_take       (w_core_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (w_result)
    );

    assign o_payload_byte  = w_result.payload_byte;
    assign o_payload_valid = w_result.payload_valid;
    assign o_status        = w_result.status;
    assign o_status_report = w_result.status_report;
    assign o_body_total    = w_result.body_total;

endmodule

`default_nettype wire

[verif/http_chunked_body_decoder_tb.sv]
// Self-checking testbench for the HTTP chunked body decoder with a built-in decoder predictor.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
    import hcbd_pkg::*;

    typedef enum logic [3:0] {
        SIZE_LINE,
        SIZE_EXT,
        SIZE_LF,
        CHUNK_DATA,
        DATA_CRLF,
        TRAILER_LINE,
        TRAILER_LF,
        BODY_DONE,
        BODY_ERROR
    } t_phase;

    localparam logic [SIZE_BITS-1:0] SIZE_GUARD = {SIZE_BITS{1'b1}} >> 4;
    localparam int HOLD_CYCLES = 120;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_in_byte = 8'h00;
    logic                 i_restart = 1'b0;
    logic                 i_sink_refuse = 1'b0;
    logic                 i_buffer_last = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           o_payload_byte;
    logic                 o_payload_valid;
    logic [1:0]           o_status;
    logic                 o_status_report;
    logic [SIZE_BITS-1:0] o_body_total;

    t_phase                    phase;
    logic [SIZE_BITS-1:0]      size_acc;
    logic [DIGIT_CNT_BITS-1:0] digits;
    logic [SIZE_BITS-1:0]      chunk_left;
    logic                      cr_seen;
    logic                      line_start;
    logic [SIZE_BITS-1:0]      delivered;

    t_result expected_results[$];
    t_result want;
    int      mismatches = 0;
    int      items_sent = 0;
    int      stall_cycles = 0;
    bit      quiet = 1'b0;
    bit      hold_on = 1'b0;

    http_chunked_body_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_restart       (i_restart),
        .i_sink_refuse   (i_sink_refuse),
        .i_buffer_last   (i_buffer_last),
        .empty           (empty),
        .pop             (pop),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_status        (o_status),
        .o_status_report (o_status_report),
        .o_body_total    (o_body_total)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_decoder();
        phase      = SIZE_LINE;
        size_acc   = '0;
        digits     = '0;
        chunk_left = '0;
        cr_seen    = 1'b0;
        line_start = 1'b0;
        delivered  = '0;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] ch, input logic rst,
                                            input logic refuse, input logic last);
        t_result    r;
        logic       hex;
        logic [3:0] nib;
        r   = '0;
        hex = 1'b1;
        nib = '0;
        if (ch >= "0" && ch <= "9") begin
            nib = 4'(ch - "0");
        end else if (ch >= "a" && ch <= "f") begin
            nib = 4'(ch - "a" + 10);
        end else if (ch >= "A" && ch <= "F") begin
            nib = 4'(ch - "A" + 10);
        end else begin
            hex = 1'b0;
        end
        if (rst) begin
            clear_decoder();
        end else begin
            case (phase)
                SIZE_LINE: begin
                    if (hex) begin
                        if (digits >= MAX_SIZE_DIGITS || size_acc > SIZE_GUARD) begin
                            phase = BODY_ERROR;
                        end else begin
                            size_acc = {size_acc[SIZE_BITS-5:0], nib};
                            digits++;
                        end
                    end else if (ch == CHAR_SEMI || ch == CHAR_CR) begin
                        if (digits == 0) phase = BODY_ERROR;
                        else phase = (ch == CHAR_SEMI) ? SIZE_EXT : SIZE_LF;
                    end else begin
                        phase = BODY_ERROR;
                    end
                end
                SIZE_EXT: begin
                    if (ch == CHAR_CR) phase = SIZE_LF;
                end
                SIZE_LF: begin
                    if (ch != CHAR_LF) begin
                        phase = BODY_ERROR;
                    end else begin
                        chunk_left = size_acc;
                        size_acc   = '0;
                        digits     = '0;
                        if (chunk_left == 0) begin
                            phase      = TRAILER_LINE;
                            line_start = 1'b1;
                        end else begin
                            phase = CHUNK_DATA;
                        end
                    end
                end
                CHUNK_DATA: begin
                    if (refuse) begin
                        phase = BODY_ERROR;
                    end else begin
                        r.payload_byte  = ch;
                        r.payload_valid = 1'b1;
                        delivered++;
                        chunk_left--;
                        if (chunk_left == 0) begin
                            phase   = DATA_CRLF;
                            cr_seen = 1'b0;
                        end
                    end
                end
                DATA_CRLF: begin
                    if (cr_seen) begin
                        if (ch != CHAR_LF) begin
                            phase = BODY_ERROR;
                        end else begin
                            cr_seen = 1'b0;
                            phase   = SIZE_LINE;
                        end
                    end else if (ch == CHAR_CR) begin
                        cr_seen = 1'b1;
                    end else begin
                        phase = BODY_ERROR;
                    end
                end
                TRAILER_LINE: begin
                    if (ch == CHAR_CR) phase = TRAILER_LF;
                    else line_start = 1'b0;
                end
                TRAILER_LF: begin
                    if (ch != CHAR_LF) begin
                        phase = BODY_ERROR;
                    end else if (line_start) begin
                        phase = BODY_DONE;
                    end else begin
                        line_start = 1'b1;
                        phase      = TRAILER_LINE;
                    end
                end
                BODY_DONE: begin
                end
                default: begin
                    phase = BODY_ERROR;
                end
            endcase
        end
        if (phase == BODY_DONE) r.status = ST_DONE;
        else if (phase == BODY_ERROR) r.status = ST_ERROR;
        else r.status = ST_MORE;
        r.status_report = last;
        r.body_total    = delivered;
        return r;
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic rst, input logic refuse,
                             input logic last);
        int gap;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 35) gap++;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_in_byte     <= ch;
        i_restart     <= rst;
        i_sink_refuse <= refuse;
        i_buffer_last <= last;
        do @(posedge i_clk); while (full);
        expected_results.push_back(decode_byte(ch, rst, refuse, last));
        items_sent++;
    endtask

    task automatic send_restart();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // The final character of the text closes a host buffer.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0, 1'b0, i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] non_cr_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
        return b;
    endfunction

    task automatic add_size_line(ref logic [7:0] q[$], input logic [63:0] sz);
        string hs;
        int    pad;
        int    ext_len;
        hs = $sformatf("%0h", sz);
        if ($urandom_range(0, 1)) hs = hs.toupper();
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17 - hs.len()) : 0;
        repeat (pad) q.push_back("0");
        for (int i = 0; i < hs.len(); i++) q.push_back(hs[i]);
        if ($urandom_range(0, 3) == 0) begin
            q.push_back(CHAR_SEMI);
            ext_len = $urandom_range(0, 4);
            repeat (ext_len) q.push_back(non_cr_byte());
        end
        q.push_back(CHAR_CR);
        q.push_back(CHAR_LF);
    endtask

    // Mostly well-formed bodies with random content; a few get one byte corrupted.
    task automatic send_random_body();
        logic [7:0]  stream[$];
        logic [63:0] sz;
        int          nchunks;
        int          n;
        bit          cut;
        cut     = 1'b0;
        nchunks = $urandom_range(0, 3);
        for (int c = 0; c < nchunks && !cut; c++) begin
            if ($urandom_range(0, 19) == 0) begin
                sz = {$urandom(), $urandom()};
                add_size_line(stream, sz);
                n = $urandom_range(1, 4);
                repeat (n) stream.push_back(8'($urandom_range(0, 255)));
                cut = 1'b1;
            end else begin
                sz = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6);
                add_size_line(stream, sz);
                repeat (sz) stream.push_back(8'($urandom_range(0, 255)));
                stream.push_back(CHAR_CR);
                stream.push_back(CHAR_LF);
            end
        end
        if (!cut) begin
            add_size_line(stream, 0);
            n = $urandom_range(0, 2);
            repeat (n) begin
                repeat ($urandom_range(1, 6)) stream.push_back(non_cr_byte());
                stream.push_back(CHAR_CR);
                stream.push_back(CHAR_LF);
            end
            stream.push_back(CHAR_CR);
            stream.push_back(CHAR_LF);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
        end
        foreach (stream[i]) begin
            if ($urandom_range(0, 49) == 0) send_restart();
            send_item(stream[i], 1'b0, $urandom_range(0, 49) == 0, $urandom_range(0, 7) == 0);
        end
        send_restart();
    endtask

    task automatic test_basic_body();
        send_restart();
        send_text("2;x\r");
        send_item(CHAR_LF, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);
        send_text("\r\n0\r\nAb\r\n\r\n");
        send_item(8'h5A, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_framing_errors();
        string bad_frames[7];
        bad_frames = '{";", "\r", "g", "1\rX", "1\r\nAY", "1\r\nA\rZ", "0\r\n\rX"};
        foreach (bad_frames[i]) begin
            send_restart();
            send_text(bad_frames[i]);
        end
    endtask

    task automatic test_digit_limit();
        send_restart();
        send_text("FFFFffffFFFFffffa");
        send_restart();
        send_text("0000000000000001a");
        send_restart();
        send_text("aF\r\n");
    endtask

    task automatic test_refused_payload();
        send_restart();
        send_text("2\r\n");
        send_item("q", 1'b0, 1'b0, 1'b0);
        send_item("r", 1'b0, 1'b1, 1'b0);
        send_item("s", 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_backpressure();
        quiet   = 1'b1;
        hold_on = 1'b1;
        send_restart();
        send_text("28\r\n");
        repeat (40) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        send_text("\r\n0\r\n\r\n");
        hold_on = 1'b0;
        quiet   = 1'b0;
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        repeat (6) send_random_body();
        quiet = 1'b0;
    endtask

    task automatic test_random_bodies();
        while (items_sent < 750) send_random_body();
    endtask

    // Each result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, o_payload_byte);
                        mismatches++;
                    end
                    if (o_payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, o_payload_valid);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_status_report !== want.status_report) begin
                        $error("status_report: expected %0d, got %0d",
                               want.status_report, o_status_report);
                        mismatches++;
                    end
                    if (o_body_total !== want.body_total) begin
                        $error("body_total: expected %0d, got %0d",
                               want.body_total, o_body_total);
                        mismatches++;
                    end
                end
            end
            if (hold_on && stall_cycles < HOLD_CYCLES) begin
                stall_cycles++;
                pop <= 1'b0;
            end else begin
                pop <= quiet || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_body();
        test_framing_errors();
        test_digit_limit();
        test_refused_payload();
        test_backpressure();
        test_streaming();
        test_random_bodies();
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[http_chunked_body_decoder] OK");
        end else begin
            $display("[http_chunked_body_decoder] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[http_chunked_body_decoder] ERROR");
        $finish;
    end

endmodule
